>>> rtl/core/vbe_pkg.sv
package vbe_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned MaxChars  = 4;
   localparam int unsigned IdxWidth  = $clog2(MaxChars);

   localparam logic [CharWidth-1:0] ChrBackslash = 8'h5C;
   localparam logic [CharWidth-1:0] ChrMeta      = 8'h4D;
   localparam logic [CharWidth-1:0] ChrCaret     = 8'h5E;
   localparam logic [CharWidth-1:0] ChrQuestion  = 8'h3F;
   localparam logic [CharWidth-1:0] ChrDash      = 8'h2D;
   localparam logic [CharWidth-1:0] ChrZero      = 8'h30;
   localparam logic [CharWidth-1:0] ChrTwo       = 8'h32;
   localparam logic [CharWidth-1:0] ChrFour      = 8'h34;

   localparam logic [CharWidth-1:0] ByteSpace    = 8'h20;
   localparam logic [CharWidth-1:0] ByteDelete   = 8'h7F;
   localparam logic [CharWidth-1:0] ByteNbsp     = 8'hA0;
   localparam logic [CharWidth-1:0] ByteTab      = 8'h09;
   localparam logic [CharWidth-1:0] ByteCr       = 8'h0D;
   localparam logic [CharWidth-1:0] CtrlOffset   = 8'h40;

   // One escape sequence: characters in order from index 0, and the
   // index of the final character.
   typedef struct packed {
      logic [MaxChars-1:0][CharWidth-1:0] chars;
      logic [IdxWidth-1:0]                last_idx;
   } seq_type;

   function automatic seq_type encode_byte(input logic [CharWidth-1:0] c,
                                           input logic                 safe_mode);
      seq_type                res;
      logic [CharWidth-1:0]   low;
      logic [CharWidth-1:0]   tail0;
      logic [CharWidth-1:0]   tail1;
      logic                   is_space;
      res      = '0;
      low      = {1'b0, c[CharWidth-2:0]};
      is_space = ((c >= ByteTab) && (c <= ByteCr)) || (c == ByteSpace);

      if (low < ByteSpace) begin
         tail0 = ChrCaret;
         tail1 = low + CtrlOffset;
      end else if (low == ByteDelete) begin
         tail0 = ChrCaret;
         tail1 = ChrQuestion;
      end else begin
         tail0 = ChrDash;
         tail1 = low;
      end

      res.chars[0] = ChrBackslash;
      if ((c > ByteSpace) && (c < ByteDelete)) begin
         res.chars[0] = c;
         res.last_idx = IdxWidth'(0);
      end else if (safe_mode && is_space) begin
         res.chars[1] = c;
         res.last_idx = IdxWidth'(1);
      end else if (c == ByteNbsp) begin
         res.chars[1] = ChrTwo;
         res.chars[2] = ChrFour;
         res.chars[3] = ChrZero;
         res.last_idx = IdxWidth'(3);
      end else if (c == ByteSpace) begin
         res.chars[1] = ChrZero;
         res.chars[2] = ChrFour;
         res.chars[3] = ChrZero;
         res.last_idx = IdxWidth'(3);
      end else if (c[CharWidth-1]) begin
         res.chars[1] = ChrMeta;
         res.chars[2] = tail0;
         res.chars[3] = tail1;
         res.last_idx = IdxWidth'(3);
      end else begin
         res.chars[1] = tail0;
         res.chars[2] = tail1;
         res.last_idx = IdxWidth'(2);
      end
      return res;
   endfunction

endpackage

>>> rtl/core/vbe_req_if.sv
interface vbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/core/vbe_rsp_if.sv
interface vbe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink (input valid, input out_char, input last, output ready);
endinterface

>>> rtl/core/vbe_csr_if.sv
interface vbe_csr_if;
   logic valid;
   logic ready;
   logic safe_mode;

   modport source (output valid, output safe_mode, input ready);
   modport sink (input valid, input safe_mode, output ready);
endinterface

>>> rtl/core/vbe_encode.sv
module vbe_encode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_byte,
   input  logic                  safe_mode,
   output logic                  seq_valid,
   output vbe_pkg::seq_type      seq,
   input  logic                  seq_take
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_fire;

   assign req_ready = !in_valid_ff || seq_take;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (seq_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_byte;
      end
   end

   assign seq_valid = in_valid_ff;
   assign seq       = vbe_pkg::encode_byte(in_byte_ff, safe_mode);

endmodule

>>> rtl/core/vbe_serial.sv
module vbe_serial (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  seq_valid,
   input  vbe_pkg::seq_type                      seq,
   output logic                                  seq_take,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [vbe_pkg::CharWidth-1:0]         rsp_char,
   output logic                                  rsp_last
);

   vbe_pkg::seq_type                 seq_ff;
   logic                             busy_ff;
   logic                             busy_in;
   logic [vbe_pkg::IdxWidth-1:0]     idx_ff;
   logic [vbe_pkg::IdxWidth-1:0]     idx_in;
   logic                             at_last;
   logic                             rsp_fire;

   assign at_last  = (idx_ff == seq_ff.last_idx);
   assign rsp_fire = busy_ff && rsp_ready;
   // The next sequence loads as the final character of this one leaves.
   assign seq_take = seq_valid && (!busy_ff || (rsp_fire && at_last));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (seq_take) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (rsp_fire) begin
         if (at_last) begin
            busy_in = 1'b0;
         end
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_take) begin
         seq_ff <= seq;
      end
   end

   assign rsp_valid = busy_ff;
   assign rsp_char  = seq_ff.chars[idx_ff];
   assign rsp_last  = at_last;

endmodule

>>> rtl/core/vis_byte_escape_encoder_core.sv
// Channel   Direction  Payload                Handshake
// req_chan  in         in_byte[7:0]           valid / ready
// rsp_chan  out        out_char[7:0], last    valid / ready
// csr_chan  in         safe_mode              valid / ready (always ready)
//
// A byte yields one to four characters, one per cycle while the receiver
// is ready; the character serializer sets the rate. With the serializer
// idle, an accepted request is registered in the encode stage and then in
// the serializer before its first character is offered.
// A request is taken while the previous sequence is still being sent.
// Synchronous reset empties both stages and clears safe_mode.
// A stalled output holds its character; a stalled input holds in its register.
module vis_byte_escape_encoder_core (
   input  logic      clock,
   input  logic      reset,
   vbe_req_if.sink   req_chan,
   vbe_rsp_if.source rsp_chan,
   vbe_csr_if.sink   csr_chan
);

   logic              safe_mode_ff;
   logic              seq_valid;
   logic              seq_take;
   vbe_pkg::seq_type  seq;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_mode_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         safe_mode_ff <= csr_chan.safe_mode;
      end
   end

   vbe_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_byte  (req_chan.in_byte),
      .safe_mode (safe_mode_ff),
      .seq_valid (seq_valid),
      .seq       (seq),
      .seq_take  (seq_take)
   );

   vbe_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .seq_valid (seq_valid),
      .seq       (seq),
      .seq_take  (seq_take),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_char  (rsp_chan.out_char),
      .rsp_last  (rsp_chan.last)
   );

endmodule

>>> rtl/core/vbe_checker.sv
module vbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char,
   input logic       rsp_last
);

   // A character that waits must not change or vanish.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) && $stable(rsp_last))
      else $error("stalled response changed");

   // A sequence is sent without gaps until its final character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside an escape sequence");

   // An accepted request with the output idle reaches the output after the encode and serializer registers.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("request did not reach the output");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind vis_byte_escape_encoder_core vbe_checker u_vbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_char  (rsp_chan.out_char),
   .rsp_last  (rsp_chan.last)
);

>>> bench/tb_vis_byte_escape_encoder_core.sv
`timescale 1ns / 100ps

module tb_vis_byte_escape_encoder_core;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } esc_char_type;

   logic clock = 1'b0;
   logic reset;

   vbe_req_if req_chan ();
   vbe_rsp_if rsp_chan ();
   vbe_csr_if csr_chan ();

   vis_byte_escape_encoder_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   esc_char_type pending_chars[$];
   logic         safe_mode_q = 1'b0;
   bit           idle_on = 1'b1;
   int           hold_cycles = 0;
   int           stall_left = 0;
   int           error_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Expected characters for one raw byte under the given mode.
   function automatic void escape_byte(input logic [7:0] raw, input logic safe);
      logic [7:0] seq [4];
      logic [7:0] low;
      int         n;
      int         k;
      n = 0;
      low = {1'b0, raw[6:0]};
      if (raw > 8'h20 && raw < 8'h7F) begin
         seq[0] = raw;
         n = 1;
      end else begin
         seq[0] = "\\";
         n = 1;
         if (safe && ((raw >= 8'h09 && raw <= 8'h0D) || raw == 8'h20)) begin
            seq[1] = raw;
            n = 2;
         end else if (raw == 8'hA0 || raw == 8'h20) begin
            seq[1] = (raw == 8'hA0) ? "2" : "0";
            seq[2] = "4";
            seq[3] = "0";
            n = 4;
         end else begin
            if (raw[7]) begin
               seq[n] = "M";
               n++;
            end
            seq[n] = (low < 8'h20 || low == 8'h7F) ? "^" : "-";
            if (low < 8'h20) begin
               seq[n+1] = low + 8'h40;
            end else if (low == 8'h7F) begin
               seq[n+1] = "?";
            end else begin
               seq[n+1] = low;
            end
            n += 2;
         end
      end
      for (k = 0; k < n; k++) begin
         pending_chars.push_back('{out_char: seq[k], last: (k == n - 1)});
      end
   endfunction

   // Biased toward the bytes that take the unusual paths.
   function automatic logic [7:0] pick_byte();
      logic [7:0] pick;
      case ($urandom_range(0, 5))
         0: pick = 8'($urandom_range(9, 13));
         1: pick = $urandom_range(0, 1) ? 8'h20 : 8'hA0;
         2: pick = $urandom_range(0, 1) ? 8'h7F : 8'hFF;
         3: pick = 8'($urandom_range(128, 159));
         default: pick = 8'($urandom());
      endcase
      return pick;
   endfunction

   task automatic send_request(input logic [7:0] raw);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= raw;
      escape_byte(raw, safe_mode_q);
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_safe_mode(input logic mode);
      csr_chan.valid     <= 1'b1;
      csr_chan.safe_mode <= mode;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      safe_mode_q = mode;
   endtask

   task automatic test_normal_mode();
      logic [7:0] bytes [17] = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h1F, 8'h20, 8'h21, 8'h41,
                                 8'h7E, 8'h7F, 8'h80, 8'h89, 8'h9F, 8'hA0, 8'hA1,
                                 8'hFE, 8'hFF};
      foreach (bytes[i]) send_request(bytes[i]);
      wait_drained();
   endtask

   task automatic test_safe_mode();
      logic [7:0] bytes [11] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'hA0, 8'h08,
                                 8'h0E, 8'h89, 8'h8A};
      write_safe_mode(1'b1);
      foreach (bytes[i]) send_request(bytes[i]);
      wait_drained();
   endtask

   // The receiver stops long enough for the block to fill and refuse requests.
   task automatic test_output_hold_off();
      hold_cycles = 80;
      repeat (24) send_request(pick_byte());
      wait_drained();
   endtask

   task automatic test_random_bytes();
      for (int phase = 0; phase < 4; phase++) begin
         write_safe_mode(phase[0] ? 1'b0 : 1'b1);
         if (phase == 3) idle_on = 1'b0;
         repeat (55) send_request(pick_byte());
         wait_drained();
      end
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      esc_char_type exp_char;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character %h with last %b", rsp_chan.out_char, rsp_chan.last);
            error_count++;
         end else begin
            exp_char = pending_chars.pop_front();
            if (rsp_chan.out_char !== exp_char.out_char) begin
               $error("out_char: expected %h, got %h", exp_char.out_char, rsp_chan.out_char);
               error_count++;
            end
            if (rsp_chan.last !== exp_char.last) begin
               $error("last: expected %b, got %b", exp_char.last, rsp_chan.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.in_byte   = 8'h00;
      csr_chan.valid     = 1'b0;
      csr_chan.safe_mode = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_normal_mode();
      test_safe_mode();
      test_output_hold_off();
      test_random_bytes();

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
